/* rtl/vpc_pkg.sv */
package vpc_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_SERVICE_ADDRESS  = 3'd0;
    localparam logic [2:0] REG_SERVICE_PORT     = 3'd1;
    localparam logic [2:0] REG_SERVICE_PROTOCOL = 3'd2;
    localparam logic [2:0] REG_DROP_ON_MATCH    = 3'd3;
    localparam logic [2:0] REG_FIRST_BACKEND    = 3'd4;
    localparam logic [2:0] REG_SECOND_BACKEND   = 3'd5;
    localparam logic [2:0] REG_BACKEND_VALID    = 3'd6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0] MIN_IHL = 4'd5;
    localparam logic [1:0] NO_BACKEND = 2'd2;

    // byte positions inside the frame
    localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
    localparam logic [6:0] POS_IHL       = 7'd14;
    localparam logic [6:0] POS_PROTOCOL  = 7'd23;
    localparam logic [6:0] POS_SRC_FIRST = 7'd26;
    localparam logic [6:0] POS_SRC_LAST  = 7'd29;
    localparam logic [6:0] POS_DST_FIRST = 7'd30;
    localparam logic [6:0] POS_DST_LAST  = 7'd33;
    localparam logic [6:0] POS_SATURATE  = 7'd127;

    localparam logic [6:0] ETH_HDR_LEN    = 7'd14;
    localparam logic [7:0] MIN_IP_FRAME   = 8'd34;
    localparam logic [7:0] TCP_HDR_LEN    = 8'd20;
    localparam logic [7:0] UDP_HDR_LEN    = 8'd8;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_word_t;

    typedef struct packed {
        logic        verdict;
        logic        matched;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  protocol_number;
        logic [1:0]  backend_index;
        logic [31:0] backend_address;
        logic [15:0] backend_svc_port;
    } out_word_t;

    typedef struct packed {
        logic [31:0] service_address;
        logic [15:0] service_port;
        logic [7:0]  service_protocol;
        logic        drop_on_match;
        logic [47:0] first_backend;
        logic [47:0] second_backend;
        logic [1:0]  backend_valid_mask;
    } cfg_t;

    // register defaults: service protocol TCP, everything else zero
    localparam cfg_t CFG_RESET = {32'd0, 16'd0, PROTO_TCP, 1'b0, 48'd0, 48'd0, 2'd0};

endpackage

/* rtl/vip_packet_classifier_top.sv */
// Classifies Ethernet frames against one configured IPv4 virtual service.
// Input channel (in_valid/in_stall/in_data): one frame byte per word, with
// frame_end set on the last byte. Output channel (out_valid/out_stall/
// out_data): exactly one result word per frame, emitted for its last byte;
// other bytes produce nothing.
// Throughput: one input word per cycle, sustained, including back-to-back
// frames, while in_stall is low. A last byte is parsed from the input
// register, and its result is valid on the output from the result register.
// The parse state and the match compare sit between the input register and
// the result register, so every byte takes a single pass.
// When the receiver stalls, the result word holds; the block keeps taking
// bytes that produce no result, and one extra word is caught in a skid slot
// before in_stall rises, so in_stall is a flop output.
// Configuration is an APB slave with 64-bit data, registers at 8*index;
// write it only while no frame is in progress.
// Reset clears the frame parse state and both channels and loads the
// register defaults (service protocol TCP, everything else zero).
module vip_packet_classifier_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  vpc_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output vpc_pkg::out_word_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vpc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [vpc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vpc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import vpc_pkg::*;

    cfg_t     cfg;
    logic     head_valid;
    in_word_t head_data;
    logic     consume;

    vpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpc_in_skid u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .head_valid (head_valid),
        .head_data  (head_data),
        .consume    (consume)
    );

    vpc_parser u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .consume    (consume),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

/* rtl/vpc_cfg_regs.sv */
module vpc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vpc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [vpc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vpc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output vpc_pkg::cfg_t                     cfg
);
    import vpc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[5:3];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SERVICE_ADDRESS:  cfg_next.service_address    = pwdata[31:0];
                REG_SERVICE_PORT:     cfg_next.service_port       = pwdata[15:0];
                REG_SERVICE_PROTOCOL: cfg_next.service_protocol   = pwdata[7:0];
                REG_DROP_ON_MATCH:    cfg_next.drop_on_match      = pwdata[0];
                REG_FIRST_BACKEND:    cfg_next.first_backend      = pwdata[47:0];
                REG_SECOND_BACKEND:   cfg_next.second_backend     = pwdata[47:0];
                REG_BACKEND_VALID:    cfg_next.backend_valid_mask = pwdata[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SERVICE_ADDRESS:  prdata = {32'd0, cfg_reg.service_address};
            REG_SERVICE_PORT:     prdata = {48'd0, cfg_reg.service_port};
            REG_SERVICE_PROTOCOL: prdata = {56'd0, cfg_reg.service_protocol};
            REG_DROP_ON_MATCH:    prdata = {63'd0, cfg_reg.drop_on_match};
            REG_FIRST_BACKEND:    prdata = {16'd0, cfg_reg.first_backend};
            REG_SECOND_BACKEND:   prdata = {16'd0, cfg_reg.second_backend};
            REG_BACKEND_VALID:    prdata = {62'd0, cfg_reg.backend_valid_mask};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/vpc_in_skid.sv */
module vpc_in_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vpc_pkg::in_word_t in_data,
    output logic              head_valid,
    output vpc_pkg::in_word_t head_data,
    input  logic              consume
);
    import vpc_pkg::*;

    logic     head_valid_reg, head_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    in_word_t head_reg, head_next;
    in_word_t skid_reg, skid_next;
    logic     accept;

    // stall is a flop: the skid slot absorbs the word in flight
    assign in_stall   = skid_valid_reg;
    assign accept     = in_valid & ~skid_valid_reg;
    assign head_valid = head_valid_reg;
    assign head_data  = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || consume)
        begin
            if (skid_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = accept;
                head_next       = in_data;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/vpc_parser.sv */
module vpc_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  vpc_pkg::cfg_t      cfg,
    input  logic               head_valid,
    input  vpc_pkg::in_word_t  head_data,
    output logic               consume,
    output logic               out_valid,
    input  logic               out_stall,
    output vpc_pkg::out_word_t out_data
);
    import vpc_pkg::*;

    logic [6:0]  offset_reg, offset_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [31:0] dst_addr_reg, dst_addr_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    logic        res_ready;
    logic        fire;
    logic        last;
    logic [7:0]  b;
    logic [6:0]  pos;
    logic [6:0]  l4;
    logic [7:0]  l4_ext;
    logic [7:0]  frame_len;
    logic        hdr_ok;
    logic        match;
    out_word_t   result;

    assign b         = head_data.frame_byte;
    assign last      = head_data.frame_end;
    assign pos       = offset_reg;
    assign res_ready = ~out_valid_reg | ~out_stall;
    assign consume   = head_valid & (~last | res_ready);
    assign fire      = consume;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign l4        = ETH_HDR_LEN + {1'b0, ihl_reg, 2'b00};
    assign l4_ext    = {1'b0, l4};
    assign frame_len = {1'b0, pos} + 8'd1;

    // The last byte of a frame that can match lies past every captured field,
    // so the decision works from the fields stored before it.
    always_comb
    begin
        hdr_ok = (etype_reg == ETHERTYPE_IPV4) && (frame_len >= MIN_IP_FRAME)
                 && (ihl_reg >= MIN_IHL);
        if (proto_reg == PROTO_TCP)
        begin
            hdr_ok = hdr_ok && (frame_len >= l4_ext + TCP_HDR_LEN);
        end
        else if (proto_reg == PROTO_UDP)
        begin
            hdr_ok = hdr_ok && (frame_len >= l4_ext + UDP_HDR_LEN);
        end
        else
        begin
            hdr_ok = 1'b0;
        end
        match = hdr_ok && (dst_addr_reg == cfg.service_address)
                && (dest_port_reg == cfg.service_port)
                && (proto_reg == cfg.service_protocol);
    end

    always_comb
    begin
        result = '0;
        if (match)
        begin
            result.verdict             = cfg.drop_on_match;
            result.matched             = 1'b1;
            result.source_address      = src_addr_reg;
            result.destination_address = dst_addr_reg;
            result.source_port         = src_port_reg;
            result.destination_port    = dest_port_reg;
            result.protocol_number     = proto_reg;
            if (cfg.backend_valid_mask[0])
            begin
                result.backend_index    = 2'd0;
                result.backend_address  = cfg.first_backend[47:16];
                result.backend_svc_port = cfg.first_backend[15:0];
            end
            else if (cfg.backend_valid_mask[1])
            begin
                result.backend_index    = 2'd1;
                result.backend_address  = cfg.second_backend[47:16];
                result.backend_svc_port = cfg.second_backend[15:0];
            end
            else
            begin
                result.backend_index   = NO_BACKEND;
            end
        end
    end

    always_comb
    begin
        offset_next    = offset_reg;
        etype_next     = etype_reg;
        ihl_next       = ihl_reg;
        proto_next     = proto_reg;
        src_addr_next  = src_addr_reg;
        dst_addr_next  = dst_addr_reg;
        src_port_next  = src_port_reg;
        dest_port_next = dest_port_reg;
        if (fire)
        begin
            if (last)
            begin
                offset_next    = '0;
                etype_next     = '0;
                ihl_next       = '0;
                proto_next     = '0;
                src_addr_next  = '0;
                dst_addr_next  = '0;
                src_port_next  = '0;
                dest_port_next = '0;
            end
            else if (pos != POS_SATURATE)
            begin
                offset_next = pos + 7'd1;
                if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO)
                begin
                    etype_next = {etype_reg[7:0], b};
                end
                if (pos == POS_IHL)
                begin
                    ihl_next = b[3:0];
                end
                if (pos == POS_PROTOCOL)
                begin
                    proto_next = b;
                end
                if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
                begin
                    src_addr_next = {src_addr_reg[23:0], b};
                end
                if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
                begin
                    dst_addr_next = {dst_addr_reg[23:0], b};
                end
                if (pos > POS_IHL)
                begin
                    if (pos == l4 || pos == l4 + 7'd1)
                    begin
                        src_port_next = {src_port_reg[7:0], b};
                    end
                    if (pos == l4 + 7'd2 || pos == l4 + 7'd3)
                    begin
                        dest_port_next = {dest_port_reg[7:0], b};
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        out_next       = out_reg;
        if (fire && last)
        begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            etype_reg     <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            src_addr_reg  <= '0;
            dst_addr_reg  <= '0;
            src_port_reg  <= '0;
            dest_port_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            etype_reg     <= etype_next;
            ihl_reg       <= ihl_next;
            proto_reg     <= proto_next;
            src_addr_reg  <= src_addr_next;
            dst_addr_reg  <= dst_addr_next;
            src_port_reg  <= src_port_next;
            dest_port_reg <= dest_port_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import vpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BACKLOG_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES = 140;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic backlog_active = 1'b0;
    event backlog_start;
    int cycle_count = 0;
    int fail_count = 0;

    in_word_t pending_bytes[$];
    out_word_t expected_verdicts[$];
    out_word_t oldest_expected;

    // shadow of the service registers and the per-frame parse state
    cfg_t svc;
    int frame_pos;
    logic [15:0] frame_etype;
    logic [3:0] frame_ihl;
    logic [7:0] frame_proto;
    logic [31:0] frame_src_ip;
    logic [31:0] frame_dst_ip;
    logic [15:0] frame_src_port;
    logic [15:0] frame_dest_port;

    vip_packet_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    function automatic void clear_frame_state();
        frame_pos = 0;
        frame_etype = '0;
        frame_ihl = '0;
        frame_proto = '0;
        frame_src_ip = '0;
        frame_dst_ip = '0;
        frame_src_port = '0;
        frame_dest_port = '0;
    endfunction

    function automatic void classify_byte(input in_word_t w);
        int l4;
        int len;
        bit hit;
        out_word_t res;
        logic [47:0] be;
        l4 = int'(ETH_HDR_LEN) + 4 * int'(frame_ihl);
        if (frame_pos < POS_SATURATE)
        begin
            if (frame_pos == POS_ETYPE_HI || frame_pos == POS_ETYPE_LO)
                frame_etype = {frame_etype[7:0], w.frame_byte};
            if (frame_pos == POS_IHL)
                frame_ihl = w.frame_byte[3:0];
            if (frame_pos == POS_PROTOCOL)
                frame_proto = w.frame_byte;
            if (frame_pos >= POS_SRC_FIRST && frame_pos <= POS_SRC_LAST)
                frame_src_ip = {frame_src_ip[23:0], w.frame_byte};
            if (frame_pos >= POS_DST_FIRST && frame_pos <= POS_DST_LAST)
                frame_dst_ip = {frame_dst_ip[23:0], w.frame_byte};
            // port offsets follow IHL, even a bogus one
            if (frame_pos > POS_IHL)
            begin
                if (frame_pos == l4 || frame_pos == l4 + 1)
                    frame_src_port = {frame_src_port[7:0], w.frame_byte};
                if (frame_pos == l4 + 2 || frame_pos == l4 + 3)
                    frame_dest_port = {frame_dest_port[7:0], w.frame_byte};
            end
        end
        if (!w.frame_end)
        begin
            if (frame_pos < POS_SATURATE)
                frame_pos++;
            return;
        end

        len = frame_pos + 1;
        l4 = int'(ETH_HDR_LEN) + 4 * int'(frame_ihl);
        hit = len >= MIN_IP_FRAME && frame_etype == ETHERTYPE_IPV4 && frame_ihl >= MIN_IHL
              && len >= l4;
        if (frame_proto == PROTO_TCP)
            hit = hit && len >= l4 + int'(TCP_HDR_LEN);
        else if (frame_proto == PROTO_UDP)
            hit = hit && len >= l4 + int'(UDP_HDR_LEN);
        else
            hit = 1'b0;
        hit = hit && frame_dst_ip == svc.service_address
              && frame_dest_port == svc.service_port
              && frame_proto == svc.service_protocol;

        res = '0;
        if (hit)
        begin
            if (svc.backend_valid_mask[0])
            begin
                res.backend_index = 2'd0;
                be = svc.first_backend;
            end
            else if (svc.backend_valid_mask[1])
            begin
                res.backend_index = 2'd1;
                be = svc.second_backend;
            end
            else
            begin
                res.backend_index = NO_BACKEND;
                be = '0;
            end
            res.verdict = svc.drop_on_match;
            res.matched = 1'b1;
            res.source_address = frame_src_ip;
            res.destination_address = frame_dst_ip;
            res.source_port = frame_src_port;
            res.destination_port = frame_dest_port;
            res.protocol_number = frame_proto;
            res.backend_address = be[47:16];
            res.backend_svc_port = be[15:0];
        end
        expected_verdicts.push_back(res);
        clear_frame_state();
    endfunction

    function automatic string show_result(input out_word_t r);
        return $sformatf({"verdict %0b matched %0b src %h dst %h sport %h dport %h",
                          " proto %h be %0d %h:%h"},
                         r.verdict, r.matched, r.source_address, r.destination_address,
                         r.source_port, r.destination_port, r.protocol_number,
                         r.backend_index, r.backend_address, r.backend_svc_port);
    endfunction

    function automatic void queue_frame(input int len, input logic [15:0] etype,
                                        input logic [3:0] ihl, input logic [7:0] proto,
                                        input logic [31:0] dst_ip,
                                        input logic [15:0] dest_port,
                                        input int fill = -1);
        int l4;
        in_word_t w;
        l4 = int'(ETH_HDR_LEN) + 4 * int'(ihl);
        for (int i = 0; i < len; i++)
        begin
            w.frame_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == POS_ETYPE_HI)
                w.frame_byte = etype[15:8];
            if (i == POS_ETYPE_LO)
                w.frame_byte = etype[7:0];
            if (i == POS_IHL)
                w.frame_byte[3:0] = ihl;   // version nibble keeps the random or fill value
            if (i == POS_PROTOCOL)
                w.frame_byte = proto;
            if (i >= POS_DST_FIRST && i <= POS_DST_LAST)
                w.frame_byte = dst_ip[8 * (int'(POS_DST_LAST) - i) +: 8];
            if (i == l4 + 2)
                w.frame_byte = dest_port[15:8];
            if (i == l4 + 3)
                w.frame_byte = dest_port[7:0];
            w.frame_end = (i == len - 1);
            pending_bytes.push_back(w);
        end
    endfunction

    // mostly well-formed frames aimed at the service, the rest short noise
    function automatic int queue_random_frame();
        int len;
        logic [15:0] etype;
        logic [3:0] ihl;
        logic [7:0] proto;
        logic [31:0] dst_ip;
        logic [15:0] dest_port;
        dst_ip = ($urandom_range(4) != 0) ? svc.service_address : $urandom;
        dest_port = ($urandom_range(4) != 0) ? svc.service_port : 16'($urandom);
        if ($urandom_range(99) < 75)
        begin
            etype = ETHERTYPE_IPV4;
            ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : MIN_IHL;
            case ($urandom_range(9))
                0, 1, 2, 3: proto = svc.service_protocol;
                4, 5: proto = PROTO_TCP;
                6, 7, 8: proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
            len = int'(ETH_HDR_LEN) + 4 * int'(ihl)
                  + ((proto == PROTO_TCP) ? int'(TCP_HDR_LEN) : int'(UDP_HDR_LEN));
            if ($urandom_range(24) == 0)
                len = $urandom_range(180, 128);
            else if ($urandom_range(6) == 0)
                len -= $urandom_range(3, 1);
            else
                len += $urandom_range(10);
        end
        else
        begin
            etype = ($urandom_range(1) != 0) ? ETHERTYPE_IPV4 : 16'($urandom);
            ihl = 4'($urandom);
            proto = ($urandom_range(1) != 0) ? svc.service_protocol : 8'($urandom);
            len = $urandom_range(40, 1);
        end
        queue_frame(len, etype, ihl, proto, dst_ip, dest_port);
        return len;
    endfunction

    function automatic logic [47:0] random_backend();
        return {$urandom, 16'($urandom)};
    endfunction

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_SERVICE_ADDRESS:  svc.service_address = value[31:0];
            REG_SERVICE_PORT:     svc.service_port = value[15:0];
            REG_SERVICE_PROTOCOL: svc.service_protocol = value[7:0];
            REG_DROP_ON_MATCH:    svc.drop_on_match = value[0];
            REG_FIRST_BACKEND:    svc.first_backend = value[47:0];
            REG_SECOND_BACKEND:   svc.second_backend = value[47:0];
            REG_BACKEND_VALID:    svc.backend_valid_mask = value[1:0];
            default: ;
        endcase
    endtask

    task automatic program_service(input logic [31:0] addr, input logic [15:0] port,
                                   input logic [7:0] proto, input logic drop,
                                   input logic [47:0] be0, input logic [47:0] be1,
                                   input logic [1:0] mask);
        write_reg(REG_SERVICE_ADDRESS, 64'(addr));
        write_reg(REG_SERVICE_PORT, 64'(port));
        write_reg(REG_SERVICE_PROTOCOL, 64'(proto));
        write_reg(REG_DROP_ON_MATCH, 64'(drop));
        write_reg(REG_FIRST_BACKEND, 64'(be0));
        write_reg(REG_SECOND_BACKEND, 64'(be1));
        write_reg(REG_BACKEND_VALID, 64'(mask));
    endtask

    // sampled at the falling edge so the check never races the driver
    task automatic drain_results();
        @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender: the prediction is taken when a word is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                classify_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: %s", show_result(out_data));
                end
                else
                begin
                    oldest_expected = expected_verdicts.pop_front();
                    if (out_data.verdict !== oldest_expected.verdict
                        || out_data.matched !== oldest_expected.matched
                        || out_data.source_address !== oldest_expected.source_address
                        || out_data.destination_address !== oldest_expected.destination_address
                        || out_data.source_port !== oldest_expected.source_port
                        || out_data.destination_port !== oldest_expected.destination_port
                        || out_data.protocol_number !== oldest_expected.protocol_number
                        || out_data.backend_index !== oldest_expected.backend_index
                        || out_data.backend_address !== oldest_expected.backend_address
                        || out_data.backend_svc_port !== oldest_expected.backend_svc_port)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result mismatch, expected %s",
                                     show_result(oldest_expected));
                            $display("                 actual   %s", show_result(out_data));
                        end
                    end
                end
            end
            out_stall <= backlog_active || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up into in_stall
    always
    begin
        @(backlog_start);
        backlog_active <= 1'b1;
        repeat (BACKLOG_CYCLES) @(posedge clk);
        backlog_active <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase_bytes;
        bit paused;
        svc = '0;
        svc.service_protocol = PROTO_TCP;
        clear_frame_state();
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 17;
        recv_idle_pct = 80;

        // register defaults: TCP to 0.0.0.0 port 0 matches, no backend valid
        queue_frame(54, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, 32'h0, 16'h0);
        drain_results();

        program_service(32'hC0A8_0A01, 16'd443, PROTO_TCP, 1'b1,
                        48'h0A00_0001_1F90, 48'h0A00_0002_0050, 2'b11);
        write_reg(REG_UNUSED, '1);
        queue_frame(54, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // shortest TCP match
        queue_frame(53, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // TCP header cut by one
        queue_frame(1, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, 32'h0, 16'h0);
        queue_frame(13, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, 32'h0, 16'h0);
        queue_frame(33, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // IP header incomplete
        queue_frame(60, ETHERTYPE_IPV6, MIN_IHL, PROTO_TCP, svc.service_address,
                    svc.service_port);
        queue_frame(60, ETHERTYPE_IPV4, 4'd4, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // IHL below minimum
        queue_frame(37, ETHERTYPE_IPV4, 4'd6, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // ends inside options
        queue_frame(94, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // max options, exact length
        queue_frame(200, ETHERTYPE_IPV4, MIN_IHL, PROTO_TCP, svc.service_address,
                    svc.service_port);                       // offset saturates
        queue_frame(42, ETHERTYPE_IPV4, MIN_IHL, PROTO_UDP, svc.service_address,
                    svc.service_port);                       // UDP vs TCP service
        queue_frame(64, 16'hFFFF, 4'hF, 8'hFF, '1, '1, 8'hFF);
        queue_frame(64, 16'h0000, 4'h0, 8'h00, '0, '0, 0);
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_service($urandom, 16'($urandom), PROTO_UDP, 1'b0,
                                   random_backend(), random_backend(), 2'b10);
                1: program_service('1, '1, PROTO_TCP, 1'b1, '1, '0, 2'b01);
                2: program_service('0, '0, PROTO_ICMP, 1'b0,
                                   random_backend(), random_backend(), 2'b00);
                3: program_service($urandom, 16'($urandom), PROTO_TCP, 1'b1,
                                   random_backend(), random_backend(), 2'b11);
                4: program_service($urandom, 16'($urandom), PROTO_UDP, 1'b0,
                                   random_backend(), random_backend(), 2'b10);
                default: program_service($urandom, 16'($urandom),
                                         ($urandom_range(1) != 0) ? PROTO_TCP : PROTO_UDP,
                                         1'($urandom), random_backend(), random_backend(),
                                         2'($urandom));
            endcase
            @(negedge clk);
            if (phase < 2)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 80;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_bytes = 0;
            if (phase == 4)
            begin
                // a run of one-word frames piles results up behind the hold-off
                for (int k = 0; k < 16; k++)
                    queue_frame(1, ETHERTYPE_IPV4, MIN_IHL, PROTO_UDP, 32'h0, 16'h0);
                phase_bytes = 16;
                -> backlog_start;
            end
            while (phase_bytes < PHASE_BYTES)
            begin
                phase_bytes += queue_random_frame();
                if (phase == 1 && !paused && phase_bytes >= PHASE_BYTES / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
            drain_results();
        end

        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
